/* src/sldf_pkg.sv */
// Package for the sync-word, length-prefixed deframer.
// Holds widths, register indexes, command kinds and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package sldf_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 16;
  localparam int LEN_LO_POS   = 3;
  localparam int LEN_HI_POS   = 4;
  localparam int FILL_W       = $clog2(HEADER_BYTES + 1);
  localparam int IDX_W        = $clog2(HEADER_BYTES);
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RST = 16'd1024;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'h55;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAYLOAD_LIMIT = 2'd0,
    REG_SYNC_FIRST    = 2'd1,
    REG_SYNC_SECOND   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_BYTE   = 2'd0,
    CMD_ABORT  = 2'd1,
    CMD_HEADER = 2'd2
  } cmd_kind_e;

  typedef logic [HEADER_BYTES-1:0][BYTE_W-1:0] window_t;

  typedef struct packed {
    cmd_kind_e kind;
    logic      last;
    window_t   hdr;
  } cmd_t;

endpackage

/* src/sldf_if.sv */
// Channel interfaces of the deframer: configuration writes, input items, results.
// Depends on sldf_pkg for field widths.
`timescale 1ns / 1ps

interface sldf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sldf_pkg::CFG_IDX_W-1:0]   index;
  logic [sldf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface sldf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [sldf_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, mode, rx_byte, input ready);
  modport sink   (input valid, mode, rx_byte, output ready);
endinterface

interface sldf_out_if;
  logic                          valid;
  logic                          ready;
  logic [sldf_pkg::BYTE_W-1:0]   out_byte;
  logic                          first_of_frame;
  logic                          last_of_frame;
  logic                          aborted;

  modport source (output valid, out_byte, first_of_frame, last_of_frame, aborted,
                  input ready);
  modport sink   (input valid, out_byte, first_of_frame, last_of_frame, aborted,
                  output ready);
endinterface

/* src/sldf_front.sv */
// Front end: configuration registers, header window and frame tracking.
// Classifies each input transaction into a command for the queue. Uses sldf_pkg.
`timescale 1ns / 1ps

module sldf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sldf_cfg_if.sink      cfg_if,
  sldf_in_if.sink       in_if,
  output logic          push_valid_o,
  output sldf_pkg::cmd_t push_cmd_o,
  input  logic          push_ready_i
);
  import sldf_pkg::*;

  logic [LEN_W-1:0]  limit_q;
  logic [BYTE_W-1:0] sync_first_q, sync_second_q;
  window_t           win_q, win_d, win_shift;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              inp_q, inp_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  hdr_len;
  logic              accept;
  logic              hdr_ok;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = push_ready_i;
  assign accept       = in_if.valid && push_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= PAYLOAD_LIMIT_RST;
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_PAYLOAD_LIMIT: limit_q       <= cfg_if.data;
        REG_SYNC_FIRST:    sync_first_q  <= cfg_if.data[BYTE_W-1:0];
        REG_SYNC_SECOND:   sync_second_q <= cfg_if.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_shift[i] = win_q[i+1];
    end
    win_shift[HEADER_BYTES-1] = in_if.rx_byte;
    hdr_len = {win_shift[LEN_HI_POS], win_shift[LEN_LO_POS]};
    hdr_ok  = (win_shift[0] == sync_first_q) && (win_shift[1] == sync_second_q) &&
              (hdr_len <= limit_q);
  end

  always_comb begin
    win_d           = win_q;
    fill_d          = fill_q;
    inp_d           = inp_q;
    rem_d           = rem_q;
    push_valid_o    = 1'b0;
    push_cmd_o.kind = CMD_BYTE;
    push_cmd_o.last = 1'b0;
    push_cmd_o.hdr  = win_shift;
    if (accept) begin
      if (in_if.mode) begin
        push_valid_o    = inp_q;
        push_cmd_o.kind = CMD_ABORT;
        push_cmd_o.last = 1'b1;
        fill_d          = '0;
        inp_d           = 1'b0;
        rem_d           = '0;
      end else if (inp_q) begin
        push_valid_o      = 1'b1;
        push_cmd_o.kind   = CMD_BYTE;
        push_cmd_o.last   = (rem_q <= LEN_W'(1));
        push_cmd_o.hdr[0] = in_if.rx_byte;
        rem_d             = rem_q - LEN_W'(rem_q != '0);
        inp_d             = (rem_d != '0);
      end else begin
        win_d = win_shift;
        if (fill_q == FILL_W'(HEADER_BYTES - 1)) begin
          if (hdr_ok) begin
            push_valid_o    = 1'b1;
            push_cmd_o.kind = CMD_HEADER;
            push_cmd_o.last = (hdr_len == '0);
            fill_d          = '0;
            rem_d           = hdr_len;
            inp_d           = (hdr_len != '0);
          end
        end else begin
          fill_d = fill_q + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      inp_q  <= 1'b0;
      rem_q  <= '0;
    end else begin
      fill_q <= fill_d;
      inp_q  <= inp_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) inp_q == (rem_q != '0))
    else $error("Payload flag disagrees with the remaining byte count.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) inp_q |-> fill_q == '0)
    else $error("Header window holds bytes while a payload is streaming.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   fill_q <= FILL_W'(HEADER_BYTES - 1))
    else $error("Header window fill exceeds one short of a header.");
`endif

endmodule

/* src/sldf_fifo.sv */
// Two-entry command queue between the front and back ends.
// Uses sldf_pkg for the entry type and depth.
`timescale 1ns / 1ps

module sldf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sldf_pkg::cmd_t push_cmd_i,
  output logic           not_full_o,
  output logic           not_empty_o,
  output sldf_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import sldf_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign not_full_o  = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> not_full_o)
    else $error("Command pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> not_empty_o)
    else $error("Command popped from an empty queue.");
`endif

endmodule

/* src/sldf_back.sv */
// Back end: expands queued commands into result transactions through an output register.
// Headers are sent one byte a cycle while the output is ready. Uses sldf_pkg.
`timescale 1ns / 1ps

module sldf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  sldf_pkg::cmd_t cmd_i,
  output logic           pop_o,
  sldf_out_if.source     out_if
);
  import sldf_pkg::*;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              first_q, first_d, last_q, last_d, abort_q, abort_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              load;
  logic              idx_end;

  assign load    = !out_valid_q || out_if.ready;
  assign idx_end = (idx_q == IDX_W'(HEADER_BYTES - 1));

  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    first_d     = first_q;
    last_d      = last_q;
    abort_d     = abort_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = cmd_valid_i;
      if (cmd_valid_i) begin
        case (cmd_i.kind)
          CMD_BYTE: begin
            byte_d  = cmd_i.hdr[0];
            first_d = 1'b0;
            last_d  = cmd_i.last;
            abort_d = 1'b0;
            pop_o   = 1'b1;
          end
          CMD_ABORT: begin
            byte_d  = '0;
            first_d = 1'b0;
            last_d  = 1'b1;
            abort_d = 1'b1;
            pop_o   = 1'b1;
          end
          CMD_HEADER: begin
            byte_d  = cmd_i.hdr[idx_q];
            first_d = (idx_q == '0);
            last_d  = cmd_i.last && idx_end;
            abort_d = 1'b0;
            pop_o   = idx_end;
            idx_d   = idx_end ? '0 : idx_q + IDX_W'(1);
          end
          default: begin
            out_valid_d = 1'b0;
            pop_o       = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    first_q <= first_d;
    last_q  <= last_d;
    abort_q <= abort_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.out_byte       = byte_q;
  assign out_if.first_of_frame = first_q;
  assign out_if.last_of_frame  = last_q;
  assign out_if.aborted        = abort_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   idx_q != '0 |-> cmd_valid_i && cmd_i.kind == CMD_HEADER)
    else $error("Header expansion in progress without a header at the queue head.");
`endif

endmodule

/* src/sync_length_frame_deframer_core.sv */
// Sync-word, length-prefixed deframer: front end, two-entry command queue, back end.
// Path: an accepted transaction is queued, then moved into the output register.
// Throughput: one input byte per cycle while payload streams and the queue has room; a
// matched header passes through the output register one header byte at a time.
// Reset: rst_ni clears control state asynchronously and restores register defaults.
`timescale 1ns / 1ps

module sync_length_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sldf_cfg_if.sink   cfg_if,
  sldf_in_if.sink    in_if,
  sldf_out_if.source out_if
);
  import sldf_pkg::*;

  logic push_valid, push_ready, not_empty, pop;
  cmd_t push_cmd, head_cmd;

  sldf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_if       (cfg_if),
    .in_if        (in_if),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  sldf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_cmd_i  (push_cmd),
    .not_full_o  (push_ready),
    .not_empty_o (not_empty),
    .head_o      (head_cmd),
    .pop_i       (pop)
  );

  sldf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (not_empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_if      (out_if)
  );

endmodule
